// ===== design/tuiv_pkg.sv =====
// tuiv_pkg: shared types, status codes and constants for the index validator.
// Used by tuiv_front, tuiv_queue, tuiv_back and the top level.
package tuiv_pkg;

  localparam int DEFAULT_MAX_ENTRIES     = 32;
  localparam int DEFAULT_MAX_TITLE_BYTES = 80;
  localparam int ID_CHARS   = 36;
  localparam int HDR_LEN    = 9;
  localparam int TITLE_W    = 7;
  localparam int INDEX_W    = 5;
  localparam int STATUS_W   = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7f;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_BAD_HEADER  = 3'd1,
    ST_FIELD_COUNT = 3'd2,
    ST_BAD_ID      = 3'd3,
    ST_BAD_TITLE   = 3'd4,
    ST_TOO_MANY    = 3'd5,
    ST_DUPLICATE   = 3'd6,
    ST_EMPTY       = 3'd7
  } status_t;

  // One finished line and/or end of text, handed from front to back.
  typedef struct packed {
    logic                line_valid;
    logic                eot;
    status_t             code;
    logic [127:0]        piece_id;
    logic [127:0]        pack_id;
    logic [TITLE_W-1:0]  title_len;
  } line_ev_t;

  function automatic logic [7:0] hdr_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0: c = 8'h76; // v
      4'd1: c = 8'h65; // e
      4'd2: c = 8'h72; // r
      4'd3: c = 8'h73; // s
      4'd4: c = 8'h69; // i
      4'd5: c = 8'h6f; // o
      4'd6: c = 8'h6e; // n
      4'd7: c = 8'h3d; // =
      4'd8: c = 8'h32; // 2
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== design/tsv_uuid_index_validator_core.sv =====
// tsv_uuid_index_validator_core: top level of the index text validator.
// Depends on tuiv_pkg, tuiv_front, tuiv_queue and tuiv_back.
//
// Takes an index text one byte per item on the s_ stream (tuser = byte
// present, tlast = end of text). The first line must read version=2; each
// further non-empty line needs a piece UUID, a pack UUID and a title,
// tab separated. Every accepted line yields a record on the m_ stream
// (tuser 0) and the end of text yields one final status (tuser 1, tlast 1);
// a non-zero status voids all records of that text. The front parser takes
// one byte every cycle while s_tready is high. Each finished line goes
// through a two-entry queue to the back end, which compares it against the
// stored entries in turn, with one table read and one compare per entry,
// and stops at the first match; lines of normal length hide this walk and
// the output handshake. s_tready drops only while the queue is full.
module tsv_uuid_index_validator_core import tuiv_pkg::*; #(
  parameter int MAX_ENTRIES     = DEFAULT_MAX_ENTRIES,
  parameter int MAX_TITLE_BYTES = DEFAULT_MAX_TITLE_BYTES
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tuser,   // has_byte
  input  logic         s_tlast,   // end_of_text
  output logic         m_tvalid,
  input  logic         m_tready,
  // piece_id_high, piece_id_low, pack_id_high, pack_id_low,
  // title_length[6:0], entry_index[4:0], status[2:0], zero pad
  output logic [271:0] m_tdata,
  output logic         m_tuser,   // kind
  output logic         m_tlast    // last
);

  logic         acc, push, q_full, q_nempty, q_pop;
  line_ev_t     ev_in, ev_out;
  logic         out_kind;
  logic [255:0] out_ids;
  logic [TITLE_W-1:0] out_title;
  logic [INDEX_W-1:0] out_index;
  status_t      out_status;

  assign s_tready = !q_full;
  assign acc      = s_tvalid && s_tready;

  tuiv_front #(.MAX_TITLE_BYTES(MAX_TITLE_BYTES)) u_front (
    .clk, .rst, .acc,
    .has_byte(s_tuser), .data_byte(s_tdata), .end_of_text(s_tlast),
    .push, .ev(ev_in)
  );

  tuiv_queue u_queue (
    .clk, .rst, .push, .wdata(ev_in), .full(q_full),
    .pop(q_pop), .nempty(q_nempty), .rdata(ev_out)
  );

  tuiv_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk, .rst, .q_nempty, .q_data(ev_out), .q_pop,
    .out_valid(m_tvalid), .out_ready(m_tready), .out_kind,
    .out_ids, .out_title, .out_index, .out_status
  );

  // ids held as {piece[127:0], pack[127:0]}; high digits go first on the bus
  assign m_tdata = {1'b0, out_status, out_index, out_title,
                    out_ids[63:0], out_ids[127:64],
                    out_ids[191:128], out_ids[255:192]};
  assign m_tuser = out_kind;
  assign m_tlast = out_kind;

endmodule

// ===== design/tuiv_front.sv =====
// tuiv_front: byte parser; checks the header, splits lines into fields and
// classifies each finished line. Depends on tuiv_pkg.
module tuiv_front import tuiv_pkg::*; #(
  parameter int MAX_TITLE_BYTES = DEFAULT_MAX_TITLE_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       acc,
  input  logic       has_byte,
  input  logic [7:0] data_byte,
  input  logic       end_of_text,
  output logic       push,
  output line_ev_t   ev
);

  localparam int CP_MAX = (MAX_TITLE_BYTES > ID_CHARS) ? MAX_TITLE_BYTES : ID_CHARS;
  localparam int CPW    = $clog2(CP_MAX + 2);

  typedef enum logic [2:0] {
    F_HDR  = 3'b001,
    F_BODY = 3'b010,
    F_FAIL = 3'b100
  } fphase_t;

  fphase_t        phase, phase_next;
  logic           hdr_fail, hdr_fail_next;
  logic [3:0]     hdr_pos, hdr_pos_next;
  logic [1:0]     field_num, field_num_next;
  logic [CPW-1:0] char_pos, char_pos_next;
  logic [127:0]   piece_id, piece_id_next, pack_id, pack_id_next;
  logic [2:0]     faults, faults_next;

  logic           is_hex, dash_pos, line_empty, do_finish;
  logic [3:0]     nib;
  status_t        lcode;

  always_comb begin
    phase_next     = phase;
    hdr_fail_next  = hdr_fail;
    hdr_pos_next   = hdr_pos;
    field_num_next = field_num;
    char_pos_next  = char_pos;
    piece_id_next  = piece_id;
    pack_id_next   = pack_id;
    faults_next    = faults;
    push           = 1'b0;
    ev             = '0;
    lcode          = ST_OK;
    line_empty     = 1'b0;
    do_finish      = 1'b0;
    is_hex   = (data_byte inside {[8'h30:8'h39], [8'h61:8'h66]});
    nib      = (data_byte <= 8'h39) ? 4'(data_byte - 8'h30) : 4'(data_byte - 8'h57);
    dash_pos = (char_pos == CPW'(8)) || (char_pos == CPW'(13)) ||
               (char_pos == CPW'(18)) || (char_pos == CPW'(23));

    if (acc && has_byte) begin
      case (phase)
        F_HDR: begin
          if (data_byte == CH_LF) begin
            if (hdr_pos == 4'(HDR_LEN)) phase_next = F_BODY;
            else begin
              phase_next    = F_FAIL;
              hdr_fail_next = 1'b1;
            end
          end else if (hdr_pos < 4'(HDR_LEN) && data_byte == hdr_char(hdr_pos)) begin
            hdr_pos_next = hdr_pos + 4'd1;
          end else begin
            phase_next    = F_FAIL;
            hdr_fail_next = 1'b1;
          end
        end
        F_BODY: begin
          if (data_byte == CH_TAB) begin
            if (field_num < 2'd2 && char_pos != CPW'(ID_CHARS))
              faults_next[field_num] = 1'b1;
            if (field_num < 2'd3) field_num_next = field_num + 2'd1;
            char_pos_next = '0;
          end else if (data_byte != CH_LF) begin
            if (field_num < 2'd2) begin
              if (char_pos >= CPW'(ID_CHARS)) begin
                faults_next[field_num] = 1'b1;
              end else begin
                if (dash_pos) begin
                  if (data_byte != CH_DASH) faults_next[field_num] = 1'b1;
                end else if (is_hex) begin
                  if (field_num == 2'd0) piece_id_next = {piece_id[123:0], nib};
                  else pack_id_next = {pack_id[123:0], nib};
                end else begin
                  faults_next[field_num] = 1'b1;
                end
                char_pos_next = char_pos + CPW'(1);
              end
            end else if (field_num == 2'd2) begin
              if (data_byte < CH_SPACE || data_byte == CH_DEL) faults_next[2] = 1'b1;
              if (char_pos <= CPW'(MAX_TITLE_BYTES)) char_pos_next = char_pos + CPW'(1);
            end
          end
        end
        default: ;
      endcase
    end

    // line end: a newline in the body, or end of text while in the body
    do_finish = acc && ((phase == F_BODY && has_byte && data_byte == CH_LF) ||
                        (end_of_text && phase_next == F_BODY));
    line_empty = (field_num_next == 2'd0) && (char_pos_next == '0);
    if (field_num_next != 2'd2) lcode = ST_FIELD_COUNT;
    else if (faults_next[1:0] != 2'b00) lcode = ST_BAD_ID;
    else if (faults_next[2] || char_pos_next == '0 ||
             char_pos_next > CPW'(MAX_TITLE_BYTES)) lcode = ST_BAD_TITLE;
    else lcode = ST_OK;

    if (do_finish && !line_empty) begin
      ev.line_valid = 1'b1;
      ev.code       = lcode;
      ev.piece_id   = piece_id_next;
      ev.pack_id    = pack_id_next;
      ev.title_len  = TITLE_W'(char_pos_next);
      if (lcode != ST_OK) phase_next = F_FAIL;
    end
    if (do_finish) begin
      field_num_next = '0;
      char_pos_next  = '0;
      piece_id_next  = '0;
      pack_id_next   = '0;
      faults_next    = '0;
    end
    if (acc && end_of_text) begin
      ev.eot = 1'b1;
      if (!ev.line_valid && (phase_next == F_HDR || hdr_fail_next))
        ev.code = ST_BAD_HEADER;
      phase_next     = F_HDR;
      hdr_fail_next  = 1'b0;
      hdr_pos_next   = '0;
      field_num_next = '0;
      char_pos_next  = '0;
      piece_id_next  = '0;
      pack_id_next   = '0;
      faults_next    = '0;
    end
    push = ev.line_valid || ev.eot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= F_HDR;
      hdr_fail  <= 1'b0;
      hdr_pos   <= '0;
      field_num <= '0;
      char_pos  <= '0;
      piece_id  <= '0;
      pack_id   <= '0;
      faults    <= '0;
    end else begin
      phase     <= phase_next;
      hdr_fail  <= hdr_fail_next;
      hdr_pos   <= hdr_pos_next;
      field_num <= field_num_next;
      char_pos  <= char_pos_next;
      piece_id  <= piece_id_next;
      pack_id   <= pack_id_next;
      faults    <= faults_next;
    end
  end

endmodule

// ===== design/tuiv_queue.sv =====
// tuiv_queue: two-entry queue of line items between front and back.
// Depends on tuiv_pkg.
module tuiv_queue import tuiv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  line_ev_t wdata,
  output logic     full,
  input  logic     pop,
  output logic     nempty,
  output line_ev_t rdata
);

  line_ev_t   slots [QUEUE_DEPTH];
  logic       wptr, rptr;
  logic [1:0] fill;

  assign full   = (fill == 2'(QUEUE_DEPTH));
  assign nempty = (fill != 2'd0);
  assign rdata  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== design/tuiv_back.sv =====
// tuiv_back: applies entry limit and duplicate check against the id table,
// emits records and the final status. Depends on tuiv_pkg.
module tuiv_back import tuiv_pkg::*; #(
  parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_nempty,
  input  line_ev_t     q_data,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         out_kind,
  output logic [255:0] out_ids,
  output logic [TITLE_W-1:0] out_title,
  output logic [INDEX_W-1:0] out_index,
  output status_t      out_status
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_READ = 6'b000010,
    B_CMP  = 6'b000100,
    B_REC  = 6'b001000,
    B_FIN  = 6'b010000,
    B_STAT = 6'b100000
  } bstate_t;

  bstate_t      state;
  line_ev_t     ev, cur;
  logic [CW-1:0] count, idx;
  status_t      err;
  logic [255:0] table_mem [MAX_ENTRIES];
  logic [255:0] rd;
  logic         tbl_we, hit;

  assign cur    = (state == B_IDLE) ? q_data : ev;
  assign q_pop  = (state == B_IDLE) && q_nempty;
  assign tbl_we = ((state == B_IDLE && q_nempty && q_data.line_valid && err == ST_OK &&
                    q_data.code == ST_OK && count < CW'(MAX_ENTRIES) && count == '0) ||
                   (state == B_CMP && !hit && idx + CW'(1) == count));
  assign hit    = (rd[255:128] == cur.piece_id) || (rd[127:0] == cur.pack_id);

  always_ff @(posedge clk) begin
    if (tbl_we) table_mem[count[IW-1:0]] <= {cur.piece_id, cur.pack_id};
    if (state == B_READ) rd <= table_mem[idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      count     <= '0;
      idx       <= '0;
      err       <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (tbl_we) begin
        // keep the item so B_REC knows whether the text ends with it
        ev         <= cur;
        out_valid  <= 1'b1;
        out_kind   <= 1'b0;
        out_ids    <= {cur.piece_id, cur.pack_id};
        out_title  <= cur.title_len;
        out_index  <= INDEX_W'(count);
        out_status <= ST_OK;
        count      <= count + CW'(1);
        state      <= B_REC;
      end else begin
        case (state)
          B_IDLE: begin
            if (q_nempty) begin
              ev    <= q_data;
              state <= q_data.eot ? B_FIN : B_IDLE;
              if (q_data.line_valid && err == ST_OK) begin
                if (q_data.code != ST_OK) err <= q_data.code;
                else if (count >= CW'(MAX_ENTRIES)) err <= ST_TOO_MANY;
                else begin
                  idx   <= '0;
                  state <= B_READ;
                end
              end
            end
          end
          B_READ: state <= B_CMP;
          B_CMP: begin
            if (hit) begin
              err   <= ST_DUPLICATE;
              state <= ev.eot ? B_FIN : B_IDLE;
            end else begin
              idx   <= idx + CW'(1);
              state <= B_READ;
            end
          end
          B_REC: begin
            if (out_ready) begin
              out_valid <= 1'b0;
              state     <= ev.eot ? B_FIN : B_IDLE;
            end
          end
          B_FIN: begin
            out_valid <= 1'b1;
            out_kind  <= 1'b1;
            out_ids   <= '0;
            out_title <= '0;
            out_index <= '0;
            if (err != ST_OK) out_status <= err;
            else if (ev.code != ST_OK) out_status <= ev.code;
            else if (count == '0) out_status <= ST_EMPTY;
            else out_status <= ST_OK;
            state <= B_STAT;
          end
          B_STAT: begin
            if (out_ready) begin
              out_valid <= 1'b0;
              count     <= '0;
              err       <= ST_OK;
              state     <= B_IDLE;
            end
          end
          default: state <= B_IDLE;
        endcase
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES)) else $error("entry count beyond limit");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == B_READ || state == B_CMP) |-> idx < count)
    else $error("duplicate walk past stored entries");
  a_rec_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_kind) |-> (out_status == ST_OK && err == ST_OK))
    else $error("record shown while an error is pending");
  a_rec_count: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && !out_kind |-> count == CW'(out_index) + CW'(1))
    else $error("record index out of step with entry count");

endmodule

// ===== verif/tb.sv =====
// tb: self-checking testbench for tsv_uuid_index_validator_core.
// Depends on tuiv_pkg and the design; streams index texts, predicts records and
// final status in a behavioral model, and checks every output item in order.
`timescale 1ns / 1ps

module tb;
  import tuiv_pkg::*;

  // Output item as seen on the m_ stream, unpacked from tdata/tuser/tlast.
  typedef struct packed {
    logic          kind;
    logic [63:0]   piece_hi;
    logic [63:0]   piece_lo;
    logic [63:0]   pack_hi;
    logic [63:0]   pack_lo;
    logic [6:0]    title_len;
    logic [4:0]    entry_idx;
    status_t       status;
    logic          last;
  } index_out_t;

  typedef enum logic [1:0] {PH_HDR, PH_BODY, PH_FAIL} parse_phase_t;

  typedef enum int {
    LN_GOOD, LN_BAD_CHAR, LN_SHORT_ID, LN_MISSING_FIELD, LN_EXTRA_FIELD,
    LN_EMPTY_TITLE, LN_LONG_TITLE, LN_CTRL_TITLE, LN_DUP_PIECE, LN_DUP_PACK,
    LN_BLANK
  } line_kind_t;

  localparam int    MAX_ENT  = DEFAULT_MAX_ENTRIES;
  localparam int    MAX_TTL  = DEFAULT_MAX_TITLE_BYTES;
  localparam string HDR_TEXT = "version=2";

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'h00;
  logic         s_tuser = 1'b0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [271:0] m_tdata;
  logic         m_tuser;
  logic         m_tlast;

  tsv_uuid_index_validator_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------
  // Behavioral model of the parser state
  // ---------------------------------------------------------------
  parse_phase_t  phase;
  int unsigned   hdr_pos;
  int unsigned   field_no;
  int unsigned   char_pos;
  logic [63:0]   id_words [4];
  logic [2:0]    line_faults;
  logic [63:0]   seen_ids [4*MAX_ENT];
  int unsigned   entry_cnt;
  status_t       first_err;

  index_out_t    expected_q[$];
  int            mismatches = 0;
  int            items_sent = 0;
  bit            calm = 1'b0;

  function automatic void add_expect(index_out_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic void clear_line();
    field_no    = 0;
    char_pos    = 0;
    foreach (id_words[i]) id_words[i] = '0;
    line_faults = '0;
  endfunction

  function automatic void reset_model();
    phase     = PH_HDR;
    hdr_pos   = 0;
    clear_line();
    entry_cnt = 0;
    first_err = ST_OK;
  endfunction

  function automatic void set_error(status_t code);
    first_err = code;
    phase     = PH_FAIL;
  endfunction

  function automatic index_out_t final_item(status_t st);
    index_out_t r;
    r = '0;
    r.kind   = 1'b1;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  // Close one body line: skip it if blank, else queue a record or latch an error.
  function automatic void close_line();
    index_out_t r;
    if (field_no == 0 && char_pos == 0) begin
      clear_line();
      return;
    end
    if (field_no != 2) begin set_error(ST_FIELD_COUNT); return; end
    if (line_faults[1:0] != 0) begin set_error(ST_BAD_ID); return; end
    if (line_faults[2] || char_pos == 0 || char_pos > MAX_TTL) begin
      set_error(ST_BAD_TITLE);
      return;
    end
    if (entry_cnt >= MAX_ENT) begin set_error(ST_TOO_MANY); return; end
    for (int i = 0; i < entry_cnt; i++) begin
      if ((seen_ids[4*i] == id_words[0] && seen_ids[4*i+1] == id_words[1]) ||
          (seen_ids[4*i+2] == id_words[2] && seen_ids[4*i+3] == id_words[3])) begin
        set_error(ST_DUPLICATE);
        return;
      end
    end
    for (int j = 0; j < 4; j++) seen_ids[4*entry_cnt+j] = id_words[j];
    r = '0;
    r.piece_hi  = id_words[0];
    r.piece_lo  = id_words[1];
    r.pack_hi   = id_words[2];
    r.pack_lo   = id_words[3];
    r.title_len = char_pos[6:0];
    r.entry_idx = entry_cnt[4:0];
    r.status    = ST_OK;
    add_expect(r);
    entry_cnt++;
    clear_line();
  endfunction

  function automatic bit is_hex_char(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "f");
  endfunction

  function automatic void body_char(logic [7:0] b);
    int unsigned w;
    logic [3:0]  nib;
    if (b == CH_TAB) begin
      if (field_no < 2 && char_pos != ID_CHARS) line_faults[field_no] = 1'b1;
      if (field_no < 3) field_no++;
      char_pos = 0;
      return;
    end
    if (field_no < 2) begin
      w = field_no * 2;
      if (char_pos >= ID_CHARS) begin
        line_faults[field_no] = 1'b1;
        return;
      end
      if (char_pos == 8 || char_pos == 13 || char_pos == 18 || char_pos == 23) begin
        if (b != CH_DASH) line_faults[field_no] = 1'b1;
      end else if (is_hex_char(b)) begin
        nib = (b <= "9") ? 4'(b - "0") : 4'(b - "a" + 10);
        id_words[w]   = {id_words[w][59:0], id_words[w+1][63:60]};
        id_words[w+1] = {id_words[w+1][59:0], nib};
      end else begin
        line_faults[field_no] = 1'b1;
      end
      char_pos++;
    end else if (field_no == 2) begin
      if (b < CH_SPACE || b == CH_DEL) line_faults[2] = 1'b1;
      if (char_pos <= MAX_TTL) char_pos++;
    end
  endfunction

  // Works out what one accepted input item produces.
  function automatic void predict_item(logic has, logic [7:0] b, logic eot);
    status_t st;
    if (has) begin
      case (phase)
        PH_HDR: begin
          if (b == CH_LF) begin
            if (hdr_pos == HDR_LEN) phase = PH_BODY;
            else set_error(ST_BAD_HEADER);
          end else if (hdr_pos < HDR_LEN && b == HDR_TEXT[hdr_pos]) begin
            hdr_pos++;
          end else begin
            set_error(ST_BAD_HEADER);
          end
        end
        PH_BODY: begin
          if (b == CH_LF) close_line();
          else body_char(b);
        end
        default: ;
      endcase
    end
    if (eot) begin
      if (phase == PH_BODY) close_line();
      if (phase == PH_HDR) st = ST_BAD_HEADER;
      else if (phase == PH_FAIL) st = first_err;
      else if (entry_cnt == 0) st = ST_EMPTY;
      else st = ST_OK;
      add_expect(final_item(st));
      reset_model();
    end
  endfunction

  // ---------------------------------------------------------------
  // Output side: random stalls and in-order checking
  // ---------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    if (rst || calm) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 11) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 13);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Handshake signals are stable at the falling edge; the item moves at the
  // next rising edge.
  always @(negedge clk) begin
    index_out_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind      = m_tuser;
      got.piece_hi  = m_tdata[63:0];
      got.piece_lo  = m_tdata[127:64];
      got.pack_hi   = m_tdata[191:128];
      got.pack_lo   = m_tdata[255:192];
      got.title_len = m_tdata[262:256];
      got.entry_idx = m_tdata[267:263];
      got.status    = status_t'(m_tdata[270:268]);
      got.last      = m_tlast;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output item: %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp kind %0d piece %h_%h pack %h_%h ttl %0d idx %0d ",
                      "st %s last %0d | got kind %0d piece %h_%h pack %h_%h ttl %0d ",
                      "idx %0d st %s last %0d"},
                     want.kind, want.piece_hi, want.piece_lo, want.pack_hi,
                     want.pack_lo, want.title_len, want.entry_idx, want.status.name(),
                     want.last, got.kind, got.piece_hi, got.piece_lo, got.pack_hi,
                     got.pack_lo, got.title_len, got.entry_idx, got.status.name(),
                     got.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------
  int quiet_left = 0;

  // Call at a rising edge; returns at the rising edge after acceptance, or later if it then inserts a random gap.
  task automatic send_item(logic has, logic [7:0] b, logic eot);
    bit ok;
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= has;
    s_tdata  <= b;
    s_tlast  <= eot;
    do begin
      @(negedge clk);
      ok = s_tready;
      @(posedge clk);
    end while (!ok);
    predict_item(has, b, eot);
    items_sent++;
    if (quiet_left > 0) quiet_left--;
    else if ($urandom_range(0, 60) == 0) quiet_left = $urandom_range(50, 300);
    if (!calm && quiet_left == 0 && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 14);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Text under construction and the ids used in it so far.
  logic [7:0]   text_q[$];
  logic [127:0] used_piece[$];
  logic [127:0] used_pack[$];

  function automatic void put_byte(logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void put_uuid(logic [127:0] v);
    int d;
    logic [3:0] n;
    d = 0;
    for (int p = 0; p < ID_CHARS; p++) begin
      if (p == 8 || p == 13 || p == 18 || p == 23) begin
        put_byte(CH_DASH);
      end else begin
        n = v[127 - 4*d -: 4];
        put_byte(n < 10 ? 8'("0" + n) : 8'("a" + n - 10));
        d++;
      end
    end
  endfunction

  function automatic logic [127:0] rand_id();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom, $urandom, $urandom};
    endcase
  endfunction

  function automatic logic [7:0] title_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h20, 8'hff));
    return (c == CH_DEL) ? 8'h80 : c;
  endfunction

  function automatic line_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 64) return LN_GOOD;
    if (r < 68) return LN_BAD_CHAR;
    if (r < 71) return LN_SHORT_ID;
    if (r < 74) return LN_MISSING_FIELD;
    if (r < 77) return LN_EXTRA_FIELD;
    if (r < 80) return LN_EMPTY_TITLE;
    if (r < 83) return LN_LONG_TITLE;
    if (r < 86) return LN_CTRL_TITLE;
    if (r < 90) return LN_DUP_PIECE;
    if (r < 94) return LN_DUP_PACK;
    return LN_BLANK;
  endfunction

  function automatic void put_line(line_kind_t k);
    logic [127:0] pc, pk;
    int start, tlen, off;
    logic [7:0] bad_chars [5];
    bad_chars = '{8'h67, 8'h41, CH_DASH, 8'h3a, CH_SPACE};
    if (k == LN_BLANK) begin
      put_byte(CH_LF);
      return;
    end
    pc = rand_id();
    pk = rand_id();
    if (k == LN_DUP_PIECE && used_piece.size() > 0)
      pc = used_piece[$urandom_range(0, used_piece.size() - 1)];
    if (k == LN_DUP_PACK && used_pack.size() > 0)
      pk = used_pack[$urandom_range(0, used_pack.size() - 1)];
    used_piece.insert(used_piece.size(), pc);
    used_pack.insert(used_pack.size(), pk);
    start = text_q.size();
    put_uuid(pc);
    put_byte(CH_TAB);
    put_uuid(pk);
    if (k == LN_BAD_CHAR) begin
      off = $urandom_range(0, 71);
      if (off >= ID_CHARS) off++;
      text_q[start + off] = bad_chars[$urandom_range(0, 4)];
    end
    if (k == LN_SHORT_ID) begin
      off = $urandom_range(0, 72);
      if (off == ID_CHARS) text_q.insert(start + off, 8'h30);
      else text_q.delete(start + off);
    end
    if (k == LN_MISSING_FIELD) begin
      put_byte(CH_LF);
      return;
    end
    put_byte(CH_TAB);
    case (k)
      LN_EMPTY_TITLE: tlen = 0;
      LN_LONG_TITLE:  tlen = $urandom_range(MAX_TTL + 1, MAX_TTL + 30);
      default: begin
        case ($urandom_range(0, 7))
          0:       tlen = 1;
          1:       tlen = MAX_TTL;
          default: tlen = $urandom_range(1, 40);
        endcase
      end
    endcase
    start = text_q.size();
    for (int i = 0; i < tlen; i++) put_byte(title_char());
    if (k == LN_CTRL_TITLE) begin
      off = start + $urandom_range(0, tlen - 1);
      text_q[off] = ($urandom_range(0, 3) == 0) ? CH_DEL : 8'($urandom_range(0, 8'h1f));
    end
    if (k == LN_EXTRA_FIELD) begin
      put_byte(CH_TAB);
      for (int i = $urandom_range(0, 5); i > 0; i--) put_byte(title_char());
    end
    put_byte(CH_LF);
  endfunction

  function automatic void put_header();
    int cut;
    put_str(HDR_TEXT);
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(0, HDR_LEN - 1);
      if ($urandom_range(0, 1)) text_q[cut] = 8'($urandom);
      else text_q = text_q[0:cut];
    end
    put_byte(CH_LF);
  endfunction

  // Sends the built text with occasional bare noise items; the end of text
  // either rides on the last byte or comes as a bare end marker.
  task automatic send_text();
    bit eot_on_byte;
    eot_on_byte = $urandom_range(0, 1);
    if (text_q.size() > 0 && text_q[$] == CH_LF && $urandom_range(0, 3) == 0)
      void'(text_q.pop_back());
    for (int i = 0; i < text_q.size(); i++) begin
      if ($urandom_range(0, 40) == 0) send_item(1'b0, 8'($urandom), 1'b0);
      send_item(1'b1, text_q[i], eot_on_byte && i == text_q.size() - 1);
    end
    if (!eot_on_byte || text_q.size() == 0) send_item(1'b0, 8'($urandom), 1'b1);
    text_q.delete();
    used_piece.delete();
    used_pack.delete();
  endtask

  // ---------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------
  task automatic test_header_cases();
    send_item(1'b0, 8'hff, 1'b1);        // end with no text at all
    send_item(1'b0, 8'h00, 1'b0);        // bare marker, no effect
    send_item(1'b1, CH_LF, 1'b1);        // newline before any header byte
    send_item(1'b1, "v", 1'b0);
    send_item(1'b1, "x", 1'b1);          // wrong header char
    for (int i = 0; i < HDR_LEN; i++)    // header without newline
      send_item(1'b1, HDR_TEXT[i], i == HDR_LEN - 1);
    put_str(HDR_TEXT);
    put_byte(CH_LF);
    for (int i = 0; i < text_q.size(); i++) send_item(1'b1, text_q[i], 1'b0);
    send_item(1'b0, 8'h55, 1'b1);        // header only: empty index
    text_q.delete();
  endtask

  task automatic test_extremes();
    put_header();
    text_q = '{};
    put_str(HDR_TEXT);
    put_byte(CH_LF);
    put_uuid('0); put_byte(CH_TAB); put_uuid('1); put_byte(CH_TAB);
    put_byte(8'h20);
    put_byte(CH_LF);
    put_uuid('1); put_byte(CH_TAB); put_uuid('0); put_byte(CH_TAB);
    for (int i = 0; i < MAX_TTL; i++) put_byte(i[0] ? 8'hff : 8'h7e);
    put_byte(CH_LF);
    send_text();
  endtask

  task automatic test_random_texts(int target);
    while (items_sent < target) begin
      put_header();
      for (int n = $urandom_range(0, 6); n > 0; n--) put_line(pick_kind());
      send_text();
    end
  endtask

  task automatic test_table_full();
    put_str(HDR_TEXT);
    put_byte(CH_LF);
    for (int n = 0; n < MAX_ENT + 1; n++) begin
      put_uuid({$urandom, $urandom, $urandom, n[31:0]});
      put_byte(CH_TAB);
      put_uuid({n[31:0], $urandom, $urandom, $urandom});
      put_byte(CH_TAB);
      put_byte(title_char());
      put_byte(CH_LF);
    end
    send_text();
  endtask

  task automatic test_no_idle_tail();
    calm = 1'b1;
    test_random_texts(items_sent + 300);
  endtask

  initial begin
    reset_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_header_cases();
    test_extremes();
    test_random_texts(1800);
    test_table_full();
    test_no_idle_tail();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
design/tuiv_pkg.sv
design/tuiv_front.sv
design/tuiv_queue.sv
design/tuiv_back.sv
design/tsv_uuid_index_validator_core.sv
verif/tb.sv
